[sv/sobet_pkg.sv]
package sobet_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 16;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int SQRT_STEPS = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [10:0] LINE_WIDTH_RST = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic signed [8:0] EDGE_THRESHOLD_RST = 9'sd0;
  localparam logic [7:0] MAG_SAT = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH,
    REG_FRAME_HEIGHT,
    REG_EDGE_THRESHOLD
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
    logic [9:0]  ax;
    logic [9:0]  ay;
  } grad_t;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic [7:0]  magnitude;
    logic        below;
    logic        last;
  } res_t;

endpackage

[sv/sobel_edge_threshold_top.sv]
// sobel edge magnitude with threshold flag, one 8-bit gray pixel per transfer
// input: raster-order pixels on in_pixel_value, transfer when in_push and !in_full
// output: one result per interior pixel, none for border pixels; the oldest
//   result sits on out_* while out_empty is low, transfer when out_pop is high
// config: cfg_we writes cfg_data to register cfg_index (0 line width,
//   1 frame height, 2 signed threshold); width or height writes restart the frame
// throughput: one pixel per clock while in_full is low, set by the line memory doing one read and
//   one write per cycle and the fully pipelined square root
// path: after its pixel transfer a result passes through the memory read,
//   gradient, middle queue, squares, 8 root stages and output queue
// reset: counters cleared, registers at their defaults, both queues empty
// receiver stall: the 16-entry output queue absorbs the root pipeline, the
//   back end stops draining the 4-entry middle queue, and in_full rises
module sobel_edge_threshold_top #(
  parameter int MAX_WIDTH = sobet_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [7:0]                        in_pixel_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [15:0]                       out_row,
  output logic [9:0]                        out_col,
  output logic [7:0]                        out_magnitude,
  output logic                              out_below_threshold,
  output logic                              out_frame_last,
  input  logic                              cfg_we,
  input  logic [sobet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobet_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int GW = $bits(sobet_pkg::grad_t);
  localparam int RW = $bits(sobet_pkg::res_t);

  logic                           grad_valid;
  sobet_pkg::grad_t               grad_data;
  logic [GW-1:0]                  mq_rd;
  sobet_pkg::grad_t               mq_data;
  logic                           mq_empty;
  logic                           mq_pop;
  logic [sobet_pkg::MQ_CNT_W-1:0] mq_count;

  logic                           res_valid;
  sobet_pkg::res_t                res_data;
  logic [RW-1:0]                  oq_rd;
  sobet_pkg::res_t                oq_data;
  logic [sobet_pkg::OQ_CNT_W-1:0] oq_count;

  sobet_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_pixel_value (in_pixel_value),
    .in_full        (in_full),
    .mq_count       (mq_count),
    .grad_valid     (grad_valid),
    .grad_data      (grad_data)
  );

  sobet_queue #(
    .WIDTH (GW),
    .DEPTH (sobet_pkg::MQ_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grad_valid),
    .push_data (grad_data),
    .pop       (mq_pop),
    .pop_data  (mq_rd),
    .empty     (mq_empty),
    .count     (mq_count)
  );

  assign mq_data = sobet_pkg::grad_t'(mq_rd);

  sobet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mq_empty  (mq_empty),
    .mq_data   (mq_data),
    .mq_pop    (mq_pop),
    .oq_count  (oq_count),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  sobet_queue #(
    .WIDTH (RW),
    .DEPTH (sobet_pkg::OQ_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .pop       (out_pop),
    .pop_data  (oq_rd),
    .empty     (out_empty),
    .count     (oq_count)
  );

  assign oq_data             = sobet_pkg::res_t'(oq_rd);
  assign out_row             = oq_data.row;
  assign out_col             = oq_data.col;
  assign out_magnitude       = oq_data.magnitude;
  assign out_below_threshold = oq_data.below;
  assign out_frame_last      = oq_data.last;

endmodule

[sv/sobet_queue.sv]
module sobet_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem[rd_ptr_r];
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/sobet_front.sv]
module sobet_front #(
  parameter int MAX_WIDTH = sobet_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sobet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobet_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_push,
  input  logic [7:0]                        in_pixel_value,
  output logic                              in_full,
  input  logic [sobet_pkg::MQ_CNT_W-1:0]    mq_count,
  output logic                              grad_valid,
  output sobet_pkg::grad_t                  grad_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [10:0]    line_width_r;
  logic [15:0]    frame_height_r;
  logic [CW:0]    w_eff;
  logic [CW:0]    w_last_full;
  logic [CW-1:0]  last_col;
  logic [15:0]    last_row;

  logic [CW-1:0]  col_r, col_nxt;
  logic [15:0]    row_r, row_nxt;
  logic           accept;
  logic           geo_write;

  logic [15:0]    line_mem [MAX_WIDTH];
  logic [15:0]    rd_q;

  logic           s1_valid_r;
  logic [7:0]     s1_pix_r;
  logic [CW-1:0]  s1_col_r;
  logic [15:0]    s1_row_r;
  logic           s1_last_r;
  logic           s1_int_r;
  logic [7:0]     win_r [6];

  logic [7:0]        up_px, mid_px;
  logic signed [11:0] p00, p01, p02, p10, p12, p20, p21, p22;
  logic signed [11:0] gx, gy, gx_neg, gy_neg;

  // effective geometry
  always_comb begin
    if (int'(line_width_r) < 3) begin
      w_eff = (CW+1)'(3);
    end else if (int'(line_width_r) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(line_width_r);
    end
  end

  assign w_last_full = w_eff - (CW+1)'(1);
  assign last_col    = w_last_full[CW-1:0];
  assign last_row    = (frame_height_r < 16'd3) ? 16'd2 : frame_height_r - 16'd1;

  assign in_full   = (int'(mq_count) + int'(s1_valid_r)) >= sobet_pkg::MQ_DEPTH;
  assign accept    = in_push && !in_full;
  assign geo_write = cfg_we && ((cfg_index == sobet_pkg::REG_LINE_WIDTH) ||
                                (cfg_index == sobet_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (geo_write) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r >= last_col) begin
        col_nxt = '0;
        row_nxt = (row_r >= last_row) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= sobet_pkg::LINE_WIDTH_RST;
      frame_height_r <= sobet_pkg::FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == sobet_pkg::REG_LINE_WIDTH)) begin
        line_width_r <= cfg_data[10:0];
      end
      if (cfg_we && (cfg_index == sobet_pkg::REG_FRAME_HEIGHT)) begin
        frame_height_r <= cfg_data[15:0];
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  // pixel stage registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pixel_value;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_last_r <= (row_r >= last_row) && (col_r >= last_col);
      s1_int_r  <= (row_r >= 16'd2) && (int'(col_r) >= 2);
    end
  end

  // line memory: upper row in the high byte, middle row in the low byte
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= line_mem[col_r];
    end
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= {mid_px, s1_pix_r};
    end
  end

  assign up_px  = rd_q[15:8];
  assign mid_px = rd_q[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_px;
      win_r[4] <= mid_px;
      win_r[5] <= s1_pix_r;
    end
  end

  assign p00 = signed'({4'b0, win_r[0]});
  assign p10 = signed'({4'b0, win_r[1]});
  assign p20 = signed'({4'b0, win_r[2]});
  assign p01 = signed'({4'b0, win_r[3]});
  assign p21 = signed'({4'b0, win_r[5]});
  assign p02 = signed'({4'b0, up_px});
  assign p12 = signed'({4'b0, mid_px});
  assign p22 = signed'({4'b0, s1_pix_r});

  assign gx = (p02 - p00) + ((p12 - p10) <<< 1) + (p22 - p20);
  assign gy = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);
  assign gx_neg = -gx;
  assign gy_neg = -gy;

  assign grad_valid     = s1_valid_r && s1_int_r;
  assign grad_data.row  = s1_row_r - 16'd1;
  assign grad_data.col  = 10'(int'(s1_col_r) - 1);
  assign grad_data.last = s1_last_r;
  assign grad_data.ax   = gx[11] ? gx_neg[9:0] : gx[9:0];
  assign grad_data.ay   = gy[11] ? gy_neg[9:0] : gy[9:0];

endmodule

[sv/sobet_back.sv]
module sobet_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sobet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobet_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              mq_empty,
  input  sobet_pkg::grad_t                  mq_data,
  output logic                              mq_pop,
  input  logic [sobet_pkg::OQ_CNT_W-1:0]    oq_count,
  output logic                              res_valid,
  output sobet_pkg::res_t                   res_data
);

  localparam int NST = sobet_pkg::SQRT_STEPS;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
    logic        sat;
    logic [15:0] v;
    logic [7:0]  r;
    logic [15:0] rsq;
  } sq_t;

  logic signed [8:0] thr_r;
  logic [NST:0]      vld_r;
  sq_t               st_r [NST+1];
  sq_t               st_nxt [NST];
  sq_t               e_nxt;
  logic [19:0]       sq_x, sq_y;
  logic [20:0]       energy;
  logic [7:0]        mag;

  // one bit of the root: try r | (1 << k), with (r | b)^2 = r^2 + r*2b + b^2
  function automatic sq_t sqrt_step(sq_t s, int k);
    sq_t         o;
    logic [16:0] cand;
    o    = s;
    cand = 17'(s.rsq) + (17'(s.r) << (k + 1)) + (17'(1) << (2 * k));
    if (cand <= 17'(s.v)) begin
      o.r   = s.r | 8'(1 << k);
      o.rsq = cand[15:0];
    end
    return o;
  endfunction

  assign mq_pop = !mq_empty &&
                  ((int'(oq_count) + $countones(vld_r)) < sobet_pkg::OQ_DEPTH);

  assign sq_x   = mq_data.ax * mq_data.ax;
  assign sq_y   = mq_data.ay * mq_data.ay;
  assign energy = 21'(sq_x) + 21'(sq_y);

  always_comb begin
    e_nxt      = '0;
    e_nxt.row  = mq_data.row;
    e_nxt.col  = mq_data.col;
    e_nxt.last = mq_data.last;
    e_nxt.sat  = |energy[20:16];
    e_nxt.v    = energy[15:0];
  end

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      st_nxt[i] = sqrt_step(st_r[i], NST - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= sobet_pkg::EDGE_THRESHOLD_RST;
      vld_r <= '0;
    end else begin
      if (cfg_we && (cfg_index == sobet_pkg::REG_EDGE_THRESHOLD)) begin
        thr_r <= signed'(cfg_data[8:0]);
      end
      vld_r <= {vld_r[NST-1:0], mq_pop};
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= e_nxt;
    for (int i = 0; i < NST; i++) begin
      st_r[i+1] <= st_nxt[i];
    end
  end

  assign mag                = st_r[NST].sat ? sobet_pkg::MAG_SAT : st_r[NST].r;
  assign res_valid          = vld_r[NST];
  assign res_data.row       = st_r[NST].row;
  assign res_data.col       = st_r[NST].col;
  assign res_data.last      = st_r[NST].last;
  assign res_data.magnitude = mag;
  assign res_data.below     = signed'({1'b0, mag}) < thr_r;

endmodule
